// File: design/qbf_pkg.sv
package qbf_pkg;

  localparam int AXES       = 2;   // x = 0, y = 1
  localparam int AXIS_X     = 0;
  localparam int AXIS_Y     = 1;
  localparam int SEG_W      = 7;   // segment count register
  localparam int COORD_W    = 32;  // twips coordinate
  localparam int WGT_W      = 2 * SEG_W;       // Bernstein weight, N^2 at most
  localparam int DEN_W      = WGT_W + 1;       // 2 * N^2
  localparam int NUM_W      = 48;              // weighted sum and rounding dividend
  localparam int QUO_W      = 32;              // quotient magnitude
  localparam int REM_W      = NUM_W - QUO_W;   // partial remainder
  localparam int DIV_BITS   = 4;               // quotient bits per divider stage
  localparam int DIV_STAGES = QUO_W / DIV_BITS;

  localparam logic [SEG_W-1:0] SEG_RESET = 7'd16;

  typedef logic        [SEG_W-1:0]   seg_t;
  typedef logic        [WGT_W-1:0]   wgt_t;
  typedef logic        [DEN_W-1:0]   den_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NUM_W-1:0]   num_t;
  typedef logic        [NUM_W-1:0]   mag_t;
  typedef logic        [QUO_W-1:0]   quo_t;
  typedef logic        [REM_W-1:0]   rem_t;

  // Control that travels beside each point through the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } ctrl_t;

  // Divider input for one axis: magnitude dividend and sign of the sum.
  typedef struct packed {
    logic neg;
    mag_t dividend;
  } div_in_t;

  // Divider lane: remainder, shared dividend/quotient shift word, sign.
  typedef struct packed {
    logic neg;
    rem_t rem;
    quo_t acc;
  } lane_t;

endpackage

// File: design/qbf_div.sv
module qbf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qbf_pkg::ctrl_t    ctrl_i,
  input  qbf_pkg::den_t     den_i,
  input  qbf_pkg::div_in_t  num_i [qbf_pkg::AXES],
  output qbf_pkg::ctrl_t    ctrl_o,
  output qbf_pkg::quo_t     quo_o [qbf_pkg::AXES],
  output logic              neg_o [qbf_pkg::AXES]
);

  localparam int Stages = qbf_pkg::DIV_STAGES;
  localparam int Axes   = qbf_pkg::AXES;

  // Restoring division, DIV_BITS quotient bits per call.
  function automatic qbf_pkg::lane_t div_step(qbf_pkg::lane_t l, qbf_pkg::den_t den);
    logic [qbf_pkg::REM_W:0] t;
    logic [qbf_pkg::REM_W:0] den_ext;
    qbf_pkg::lane_t          r;
    r       = l;
    den_ext = {{(qbf_pkg::REM_W + 1 - qbf_pkg::DEN_W){1'b0}}, den};
    for (int i = 0; i < qbf_pkg::DIV_BITS; i++) begin
      t     = {r.rem, r.acc[qbf_pkg::QUO_W-1]};
      r.acc = {r.acc[qbf_pkg::QUO_W-2:0], 1'b0};
      if (t >= den_ext) begin
        t        = t - den_ext;
        r.acc[0] = 1'b1;
      end
      r.rem = t[qbf_pkg::REM_W-1:0];
    end
    return r;
  endfunction

  qbf_pkg::ctrl_t ctrl_q  [Stages];
  qbf_pkg::den_t  den_q   [Stages];
  qbf_pkg::ctrl_t ctrl_in [Stages];
  qbf_pkg::den_t  den_in  [Stages];
  qbf_pkg::lane_t lane_q  [Stages][Axes];
  qbf_pkg::lane_t lane_in [Stages][Axes];

  for (genvar st = 0; st < Stages; st++) begin : g_stage
    if (st == 0) begin : g_first
      assign ctrl_in[st] = ctrl_i;
      assign den_in[st]  = den_i;
      for (genvar ax = 0; ax < Axes; ax++) begin : g_axis
        always_comb begin
          lane_in[st][ax].neg = num_i[ax].neg;
          lane_in[st][ax].rem = num_i[ax].dividend[qbf_pkg::NUM_W-1 -: qbf_pkg::REM_W];
          lane_in[st][ax].acc = num_i[ax].dividend[qbf_pkg::QUO_W-1:0];
        end
      end
    end else begin : g_next
      assign ctrl_in[st] = ctrl_q[st-1];
      assign den_in[st]  = den_q[st-1];
      for (genvar ax = 0; ax < Axes; ax++) begin : g_axis
        assign lane_in[st][ax] = lane_q[st-1][ax];
      end
    end

    for (genvar ax = 0; ax < Axes; ax++) begin : g_lane
      always_ff @(posedge clk_i) begin
        lane_q[st][ax] <= div_step(lane_in[st][ax], den_in[st]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[st] <= '0;
      end else begin
        ctrl_q[st] <= ctrl_in[st];
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[st] <= den_in[st];
    end
  end

  assign ctrl_o = ctrl_q[Stages-1];

  for (genvar ax = 0; ax < Axes; ax++) begin : g_out
    assign quo_o[ax] = lane_q[Stages-1][ax].acc;
    assign neg_o[ax] = lane_q[Stages-1][ax].neg;
  end

endmodule

// File: design/quadratic_bezier_flattener.sv
// Channel   | Direction | Signals                                   | Transfer rule
// ----------+-----------+-------------------------------------------+-------------------------------
// command   | in        | start, busy, start/ctrl/end x and y       | start high while busy low
// config    | in        | cfg_we_i, cfg_wdata_i (segment_count)     | cfg_we_i high, no wait
// result    | out       | point_valid_o, point_x_o, point_y_o,      | one cycle per strobe,
//           |           | last_point_o                              | receiver cannot hold off
//
// A curve yields N points, N = segment_count with zero read as one and values above
// MAX_SEGMENTS capped. The point sequencer issues one point per cycle and takes the next
// curve in the cycle its last point issues. A point passes the sequencer, the weight,
// product, sum and rounding stages, the 8-stage quotient pipeline (4 bits a stage)
// and the output register before it appears.
// Reset clears the sequencer and every valid bit; the segment count returns to 16.
// The result side never stalls: points of one curve leave in consecutive cycles.
module quadratic_bezier_flattener #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command transaction
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    start_x_i,
  input  logic signed [31:0]    start_y_i,
  input  logic signed [31:0]    ctrl_x_i,
  input  logic signed [31:0]    ctrl_y_i,
  input  logic signed [31:0]    end_x_i,
  input  logic signed [31:0]    end_y_i,
  // segment_count register
  input  logic                  cfg_we_i,
  input  logic [6:0]            cfg_wdata_i,
  // result transaction
  output logic                  point_valid_o,
  output logic signed [31:0]    point_x_o,
  output logic signed [31:0]    point_y_o,
  output logic                  last_point_o
);

  localparam int Axes   = qbf_pkg::AXES;
  localparam int SegMax = (2 ** qbf_pkg::SEG_W) - 1;
  localparam int SegCapInt = (MAX_SEGMENTS > SegMax) ? SegMax : MAX_SEGMENTS;
  localparam qbf_pkg::seg_t SEG_CAP = qbf_pkg::seg_t'(SegCapInt);
  localparam qbf_pkg::seg_t SEG_ONE = qbf_pkg::seg_t'(1);

  // ------------------------------------------------------------------
  // Configuration register
  // ------------------------------------------------------------------
  qbf_pkg::seg_t seg_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= qbf_pkg::SEG_RESET;
    end else if (cfg_we_i) begin
      seg_count_q <= cfg_wdata_i;
    end
  end

  // Effective segment count: zero reads as one, cap at MAX_SEGMENTS.
  qbf_pkg::seg_t n_eff;
  always_comb begin
    priority if (seg_count_q == '0) begin
      n_eff = SEG_ONE;
    end else if (seg_count_q > SEG_CAP) begin
      n_eff = SEG_CAP;
    end else begin
      n_eff = seg_count_q;
    end
  end

  // ------------------------------------------------------------------
  // Point sequencer: walks s = 1..N, one point per cycle
  // ------------------------------------------------------------------
  logic           active_q, active_d;
  qbf_pkg::seg_t  s_q, s_d;
  qbf_pkg::seg_t  n_q;
  qbf_pkg::coord_t p0_q [Axes];
  qbf_pkg::coord_t pc_q [Axes];
  qbf_pkg::coord_t pa_q [Axes];
  logic           accept;
  logic           issue_last;

  // Busy drops on the last issue so the next curve follows without a gap.
  assign issue_last = active_q && (s_q == n_q);
  assign busy       = active_q && (s_q != n_q);
  assign accept     = start && !busy;

  always_comb begin
    active_d = active_q;
    s_d      = s_q;
    priority if (accept) begin
      active_d = 1'b1;
      s_d      = SEG_ONE;
    end else if (issue_last) begin
      active_d = 1'b0;
    end else if (active_q) begin
      s_d = s_q + SEG_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      s_q      <= '0;
    end else begin
      active_q <= active_d;
      s_q      <= s_d;
    end
  end

  // Hold the curve for the whole walk; the last issue reads it on the same edge.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q                    <= n_eff;
      p0_q[qbf_pkg::AXIS_X]  <= start_x_i;
      p0_q[qbf_pkg::AXIS_Y]  <= start_y_i;
      pc_q[qbf_pkg::AXIS_X]  <= ctrl_x_i;
      pc_q[qbf_pkg::AXIS_Y]  <= ctrl_y_i;
      pa_q[qbf_pkg::AXIS_X]  <= end_x_i;
      pa_q[qbf_pkg::AXIS_Y]  <= end_y_i;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: Bernstein weights (N-s)^2, 2(N-s)s, s^2 and N^2
  // ------------------------------------------------------------------
  qbf_pkg::seg_t   r_cnt;
  qbf_pkg::ctrl_t  s1_ctrl_q;
  qbf_pkg::wgt_t   s1_w0_q, s1_w1_q, s1_w2_q, s1_den_q;
  qbf_pkg::coord_t s1_c0_q [Axes];
  qbf_pkg::coord_t s1_cc_q [Axes];
  qbf_pkg::coord_t s1_ca_q [Axes];

  assign r_cnt = n_q - s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctrl_q <= '0;
    end else begin
      s1_ctrl_q.valid <= active_q;
      s1_ctrl_q.last  <= issue_last;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_w0_q  <= qbf_pkg::wgt_t'(r_cnt) * qbf_pkg::wgt_t'(r_cnt);
    s1_w1_q  <= (qbf_pkg::wgt_t'(r_cnt) * qbf_pkg::wgt_t'(s_q)) << 1;
    s1_w2_q  <= qbf_pkg::wgt_t'(s_q) * qbf_pkg::wgt_t'(s_q);
    s1_den_q <= qbf_pkg::wgt_t'(n_q) * qbf_pkg::wgt_t'(n_q);
    s1_c0_q  <= p0_q;
    s1_cc_q  <= pc_q;
    s1_ca_q  <= pa_q;
  end

  // ------------------------------------------------------------------
  // Stage 2: weight times coordinate, 32 x 15 signed, per axis
  // ------------------------------------------------------------------
  qbf_pkg::ctrl_t s2_ctrl_q;
  qbf_pkg::wgt_t  s2_den_q;
  qbf_pkg::num_t  s2_m0_q [Axes];
  qbf_pkg::num_t  s2_m1_q [Axes];
  qbf_pkg::num_t  s2_m2_q [Axes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctrl_q <= '0;
    end else begin
      s2_ctrl_q <= s1_ctrl_q;
    end
  end

  for (genvar ax = 0; ax < Axes; ax++) begin : g_mul
    always_ff @(posedge clk_i) begin
      s2_m0_q[ax] <= qbf_pkg::num_t'(s1_c0_q[ax] * $signed({1'b0, s1_w0_q}));
      s2_m1_q[ax] <= qbf_pkg::num_t'(s1_cc_q[ax] * $signed({1'b0, s1_w1_q}));
      s2_m2_q[ax] <= qbf_pkg::num_t'(s1_ca_q[ax] * $signed({1'b0, s1_w2_q}));
    end
  end

  always_ff @(posedge clk_i) begin
    s2_den_q <= s1_den_q;
  end

  // ------------------------------------------------------------------
  // Stage 3: weighted sum; magnitude stays below 2^45
  // ------------------------------------------------------------------
  qbf_pkg::ctrl_t s3_ctrl_q;
  qbf_pkg::wgt_t  s3_den_q;
  qbf_pkg::num_t  s3_num_q [Axes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctrl_q <= '0;
    end else begin
      s3_ctrl_q <= s2_ctrl_q;
    end
  end

  for (genvar ax = 0; ax < Axes; ax++) begin : g_sum
    always_ff @(posedge clk_i) begin
      s3_num_q[ax] <= s2_m0_q[ax] + s2_m1_q[ax] + s2_m2_q[ax];
    end
  end

  always_ff @(posedge clk_i) begin
    s3_den_q <= s2_den_q;
  end

  // ------------------------------------------------------------------
  // Stage 4: round half away from zero as floor((2|num| + d) / 2d)
  // ------------------------------------------------------------------
  qbf_pkg::ctrl_t   s4_ctrl_q;
  qbf_pkg::den_t    s4_den2_q;
  qbf_pkg::div_in_t s4_lane_q [Axes];
  qbf_pkg::mag_t    mag [Axes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_ctrl_q <= '0;
    end else begin
      s4_ctrl_q <= s3_ctrl_q;
    end
  end

  for (genvar ax = 0; ax < Axes; ax++) begin : g_round
    assign mag[ax] = s3_num_q[ax][qbf_pkg::NUM_W-1] ? qbf_pkg::mag_t'(-s3_num_q[ax])
                                                    : qbf_pkg::mag_t'(s3_num_q[ax]);
    always_ff @(posedge clk_i) begin
      s4_lane_q[ax].neg      <= s3_num_q[ax][qbf_pkg::NUM_W-1];
      s4_lane_q[ax].dividend <= {mag[ax][qbf_pkg::NUM_W-2:0], 1'b0}
                              + {{(qbf_pkg::NUM_W - qbf_pkg::WGT_W){1'b0}}, s3_den_q};
    end
  end

  always_ff @(posedge clk_i) begin
    s4_den2_q <= {s3_den_q, 1'b0};
  end

  // ------------------------------------------------------------------
  // Quotient pipeline
  // ------------------------------------------------------------------
  qbf_pkg::ctrl_t div_ctrl;
  qbf_pkg::quo_t  div_quo [Axes];
  logic           div_neg [Axes];

  qbf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (s4_ctrl_q),
    .den_i  (s4_den2_q),
    .num_i  (s4_lane_q),
    .ctrl_o (div_ctrl),
    .quo_o  (div_quo),
    .neg_o  (div_neg)
  );

  // ------------------------------------------------------------------
  // Output register: restore sign, drive the strobe
  // ------------------------------------------------------------------
  logic            point_valid_q, last_point_q;
  qbf_pkg::coord_t point_q [Axes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_valid_q <= 1'b0;
      last_point_q  <= 1'b0;
    end else begin
      point_valid_q <= div_ctrl.valid;
      last_point_q  <= div_ctrl.valid && div_ctrl.last;
    end
  end

  for (genvar ax = 0; ax < Axes; ax++) begin : g_sign
    always_ff @(posedge clk_i) begin
      point_q[ax] <= div_neg[ax] ? $signed(qbf_pkg::quo_t'(0) - div_quo[ax])
                                 : $signed(div_quo[ax]);
    end
  end

  assign point_valid_o = point_valid_q;
  assign last_point_o  = last_point_q;
  assign point_x_o     = point_q[qbf_pkg::AXIS_X];
  assign point_y_o     = point_q[qbf_pkg::AXIS_Y];

endmodule

// File: design/qbf_chk.sv
module qbf_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] start_x_i,
  input logic signed [31:0] start_y_i,
  input logic signed [31:0] ctrl_x_i,
  input logic signed [31:0] ctrl_y_i,
  input logic signed [31:0] end_x_i,
  input logic signed [31:0] end_y_i,
  input logic               cfg_we_i,
  input logic [6:0]         cfg_wdata_i,
  input logic               point_valid_o,
  input logic signed [31:0] point_x_o,
  input logic signed [31:0] point_y_o,
  input logic               last_point_o
);

  // Busy only rises after a command transaction.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // The last flag only rides on a strobed point.
  a_last_on_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_point_o |-> point_valid_o)
    else $error("last_point_o without point_valid_o");

  // Points of one curve leave in consecutive cycles until the last one.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_valid_o && !last_point_o) |=> point_valid_o)
    else $error("gap inside a curve's point stream");

endmodule

bind quadratic_bezier_flattener qbf_chk u_qbf_chk (.*);
